### hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds across reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Constants and types shared by the console line editor modules.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int BUFFER_DEPTH = 128;
   localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int PTR_W        = $clog2(2 * BUFFER_DEPTH);
   localparam int CHAR_W       = 8;

   // Request kinds
   localparam logic KIND_RX  = 1'b0;
   localparam logic KIND_POP = 1'b1;

   // Control characters
   localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CH_EOF  = 8'h04;
   localparam logic [CHAR_W-1:0] CH_BS   = 8'h08;
   localparam logic [CHAR_W-1:0] CH_LF   = 8'h0a;
   localparam logic [CHAR_W-1:0] CH_CR   = 8'h0d;
   localparam logic [CHAR_W-1:0] CH_DIAG = 8'h10;
   localparam logic [CHAR_W-1:0] CH_KILL = 8'h15;
   localparam logic [CHAR_W-1:0] CH_DEL  = 8'h7f;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CHAR_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   // Fields settled at accept time; the popped character follows from the RAM.
   typedef struct packed {
      logic              echo_valid;
      logic [CHAR_W-1:0] echo_char;
      logic [7:0]        erase_count;
      logic              dropped;
      logic              line_ready;
      logic              is_pop;
      logic              pop_hit;
   } edit_result_type;

endpackage

### hw/rtl/cle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Hold the last read while no new read is issued.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/cle_pointer_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pointer_ctrl
// Read, commit and edit pointers of the line ring, and the edit decisions
// taken for each accepted request.
// ----------------------------------------------------------------------------
module cle_pointer_ctrl
   import cle_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              kind,
   input  logic [CHAR_W-1:0] rx_byte,
   output ram_req_type       ram_req,
   output edit_result_type   result
);

   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(2 * BUFFER_DEPTH - 1);
   localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(BUFFER_DEPTH);
   localparam logic [PTR_W:0]   MOD_X   = (PTR_W + 1)'(2 * BUFFER_DEPTH);

   logic [PTR_W-1:0] read_ff, read_in;
   logic [PTR_W-1:0] commit_ff, commit_in;
   logic [PTR_W-1:0] edit_ff, edit_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_MAX) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_MAX : p - 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
      logic [PTR_W:0] wrapped;
      wrapped = {1'b0, a} + MOD_X - {1'b0, b};
      return (a >= b) ? a - b : wrapped[PTR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] s;
      s = (p >= DEPTH_P) ? p - DEPTH_P : p;
      return s[ADDR_W-1:0];
   endfunction

   function automatic logic [7:0] sat8(input logic [PTR_W-1:0] n);
      logic [31:0] wide;
      wide = 32'(n);
      return (wide > 32'd255) ? 8'hff : wide[7:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff   <= '0;
         commit_ff <= '0;
         edit_ff   <= '0;
      end else begin
         read_ff   <= read_in;
         commit_ff <= commit_in;
         edit_ff   <= edit_in;
      end
   end

   always_comb begin
      logic [CHAR_W-1:0] ch;
      logic [PTR_W-1:0]  edit_next;
      ch        = (rx_byte == CH_CR) ? CH_LF : rx_byte;
      edit_next = ptr_inc(edit_ff);
      read_in   = read_ff;
      commit_in = commit_ff;
      edit_in   = edit_ff;
      ram_req   = '0;
      result    = '0;
      if (accept) begin
         if (kind == KIND_RX) begin
            case (rx_byte) inside
               CH_KILL: begin
                  result.erase_count = sat8(ptr_dist(edit_ff, commit_ff));
                  edit_in            = commit_ff;
               end
               CH_BS, CH_DEL: begin
                  if (edit_ff != commit_ff) begin
                     edit_in            = ptr_dec(edit_ff);
                     result.erase_count = 8'd1;
                  end
               end
               CH_DIAG: begin
                  // consume without effect
               end
               default: begin
                  if (rx_byte == CH_NUL || ptr_dist(edit_ff, read_ff) >= DEPTH_P) begin
                     result.dropped = 1'b1;
                  end else begin
                     result.echo_valid = 1'b1;
                     result.echo_char  = ch;
                     ram_req.we        = 1'b1;
                     ram_req.waddr     = slot_of(edit_ff);
                     ram_req.wdata     = ch;
                     edit_in           = edit_next;
                     // commit on end of line, end of file or a full ring
                     if (ch == CH_LF || ch == CH_EOF ||
                         ptr_dist(edit_next, read_ff) == DEPTH_P) begin
                        commit_in         = edit_next;
                        result.line_ready = 1'b1;
                     end
                  end
               end
            endcase
         end else begin
            result.is_pop = 1'b1;
            if (read_ff != commit_ff) begin
               result.pop_hit = 1'b1;
               ram_req.re     = 1'b1;
               ram_req.raddr  = slot_of(read_ff);
               read_in        = ptr_inc(read_ff);
            end
         end
      end
   end

endmodule

### hw/rtl/console_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor
// Canonical line editor for console input, built around a character RAM.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while the response side is not stalled,
// and each gives exactly one response, registered first in stage one and then
// in the response register. Pointer updates finish in the accept cycle, so
// requests never wait on each other; only a pop reads the RAM, whose read port
// is registered. The ring holds BUFFER_DEPTH characters (128 here) and needs no
// clearing after reset.
module console_line_editor
   import cle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] echo_valid, [8:1] echo_char, [16:9] erase_count, [17] dropped,
   // [18] line_ready, [19] read_valid, [27:20] read_char, [28] read_eof,
   // [29] read_line_end, [30] read_empty, [31] zero
   output logic [31:0] rsp_tdata
);

   ram_req_type       ram_req;
   edit_result_type   result;
   logic [CHAR_W-1:0] rdata;
   logic              accept;
   logic              s1_move;

   logic              s1_valid_ff, s1_valid_in;
   edit_result_type   s1_res_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   cle_pointer_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .kind    (req_tuser[0]),
      .rx_byte (req_tdata),
      .ram_req (ram_req),
      .result  (result)
   );

   cle_ram #(
      .DATA_W (CHAR_W),
      .DEPTH  (BUFFER_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (rdata)
   );

   always_comb begin
      logic hit;
      logic is_eof;
      hit          = s1_res_ff.pop_hit;
      is_eof       = hit && (rdata == CH_EOF);
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = '0;
      rsp_data_in[0]     = s1_res_ff.echo_valid;
      rsp_data_in[8:1]   = s1_res_ff.echo_char;
      rsp_data_in[16:9]  = s1_res_ff.erase_count;
      rsp_data_in[17]    = s1_res_ff.dropped;
      rsp_data_in[18]    = s1_res_ff.line_ready;
      rsp_data_in[19]    = hit && !is_eof;
      rsp_data_in[27:20] = (hit && !is_eof) ? rdata : '0;
      rsp_data_in[28]    = is_eof;
      rsp_data_in[29]    = hit && (rdata == CH_LF);
      rsp_data_in[30]    = s1_res_ff.is_pop && !hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load stage one on accept, the response register on advance.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= result;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hw/rtl/cle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks for the console line editor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   `ASSERT_CLK(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "response valid after reset")
   `ASSERT_CLK_RST(a_hold_stall, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `ASSERT_CLK_RST(a_echo_or_drop, clock, reset, rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[17]), "echo and drop together")
   `ASSERT_CLK_RST(a_pop_outcome, clock, reset, rsp_tvalid |-> $countones({rsp_tdata[19], rsp_tdata[28], rsp_tdata[30]}) <= 1, "pop outcomes overlap")
   `ASSERT_CLK_RST(a_read_char_zero, clock, reset, rsp_tvalid && !rsp_tdata[19] |-> rsp_tdata[27:20] == 8'h00 && !rsp_tdata[29], "read fields set without delivery")

endmodule

bind console_line_editor cle_checker u_cle_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
